// ----- sv/tsf_pkg.sv -----
// constants, types and the dither table for the filtered texture sampler
// no dependencies
package tsf_pkg;

    localparam int MAX_WIDTH    = 64;
    localparam int MAX_HEIGHT   = 64;
    localparam int UV_FRAC_BITS = 16;

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int SZW  = 7;
    localparam int UVW  = UV_FRAC_BITS + 1;
    localparam int PW   = UV_FRAC_BITS + ((XW > YW) ? XW : YW) + 1;
    localparam int WW   = 2 * UV_FRAC_BITS + 1;
    localparam int PRW  = WW + 8;
    localparam int ACW  = PRW + 2;
    localparam int BAW  = (XW - 1) + (YW - 1);
    localparam int BDEP = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);

    localparam logic [1:0] REG_TEX_WIDTH   = 2'd0;
    localparam logic [1:0] REG_TEX_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_FILTER_MODE = 2'd2;

    localparam logic [1:0] MODE_NEAREST  = 2'd0;
    localparam logic [1:0] MODE_DITHER   = 2'd1;
    localparam logic [1:0] MODE_BILINEAR = 2'd2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef logic [31:0] texel_t;

    // ordered offsets in quarters, {u, v}, picked by screen parity
    function automatic logic [3:0] dither_q(input logic sy, input logic sx);
        logic [3:0] q;
        case ({sy, sx})
            2'b00:   q = {2'd1, 2'd0};
            2'b01:   q = {2'd2, 2'd3};
            2'b10:   q = {2'd3, 2'd2};
            default: q = {2'd0, 2'd1};
        endcase
        return q;
    endfunction

endpackage

// ----- sv/texture_sampler_filtered_unit.sv -----
// texture sampler over a four-bank rgba8 texel store, nearest, dithered and bilinear
// a result becomes valid once its accepted request has passed five register stages
// throughput one request per cycle; the whole pipeline advances whenever the result
// register is empty or being taken, and four parity banks let bilinear read all neighbours
// reset clears valid bits and the registers (size 64x64, nearest); texel content is kept undefined
// depends on tsf_pkg
module texture_sampler_filtered_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [6:0]                 cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_op,
    input  logic [5:0]                 s_texel_x,
    input  logic [5:0]                 s_texel_y,
    input  logic [16:0]                s_coord_u,
    input  logic [16:0]                s_coord_v,
    input  logic                       s_screen_x_odd,
    input  logic                       s_screen_y_odd,
    input  logic [7:0]                 s_texel_red,
    input  logic [7:0]                 s_texel_green,
    input  logic [7:0]                 s_texel_blue,
    input  logic [7:0]                 s_texel_alpha,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_out_red,
    output logic [7:0]                 m_out_green,
    output logic [7:0]                 m_out_blue,
    output logic [7:0]                 m_out_alpha
);
    import tsf_pkg::*;

    localparam logic [UVW-1:0] UV_ONE = UVW'(1) << UV_FRAC_BITS;

    logic [SZW-1:0] width_reg, height_reg;
    logic [1:0]     mode_reg;
    logic [SZW-1:0] cfg_size;
    logic           en;

    // configuration: size clamps to 1..max
    always_comb begin
        if (cfg_wdata == '0) begin
            cfg_size = SZW'(1);
        end else begin
            cfg_size = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SZW'(MAX_WIDTH);
            height_reg <= SZW'(MAX_HEIGHT);
            mode_reg   <= MODE_NEAREST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TEX_WIDTH:   width_reg  <= (cfg_size > SZW'(MAX_WIDTH)) ?
                                               SZW'(MAX_WIDTH) : cfg_size;
                REG_TEX_HEIGHT:  height_reg <= (cfg_size > SZW'(MAX_HEIGHT)) ?
                                               SZW'(MAX_HEIGHT) : cfg_size;
                REG_FILTER_MODE: mode_reg   <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage 1: saturate coordinates and scale by size minus one
    logic [UVW-1:0] cu_sat, cv_sat;
    logic [XW-1:0]  wm1;
    logic [YW-1:0]  hm1;
    assign cu_sat = (s_coord_u > UV_ONE) ? UV_ONE : s_coord_u;
    assign cv_sat = (s_coord_v > UV_ONE) ? UV_ONE : s_coord_v;
    assign wm1    = XW'(width_reg - SZW'(1));
    assign hm1    = YW'(height_reg - SZW'(1));

    logic          v1_reg, op1_reg, sx1_reg, sy1_reg;
    logic [XW-1:0] tx1_reg;
    logic [YW-1:0] ty1_reg;
    texel_t        tex1_reg;
    logic [PW-1:0] pu1_reg, pv1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg  <= s_op;
            sx1_reg  <= s_screen_x_odd;
            sy1_reg  <= s_screen_y_odd;
            tx1_reg  <= s_texel_x;
            ty1_reg  <= s_texel_y;
            tex1_reg <= {s_texel_alpha, s_texel_blue, s_texel_green, s_texel_red};
            pu1_reg  <= PW'(cu_sat) * PW'(wm1);
            pv1_reg  <= PW'(cv_sat) * PW'(hm1);
        end
    end

    // stage 2: neighbour coordinates, dither and rounding, bank addressing
    logic [XW-1:0] x0, x1, xr, xa, xb;
    logic [YW-1:0] y0, y1, yr, ya, yb;
    logic [UV_FRAC_BITS-1:0] fx, fy;
    logic [PW-1:0] pdu, pdv, ru, rv;
    logic [3:0]    dq;
    logic          bil1;

    assign fx   = pu1_reg[UV_FRAC_BITS-1:0];
    assign fy   = pv1_reg[UV_FRAC_BITS-1:0];
    assign x0   = XW'(pu1_reg >> UV_FRAC_BITS);
    assign y0   = YW'(pv1_reg >> UV_FRAC_BITS);
    assign x1   = x0 + XW'(fx != '0);
    assign y1   = y0 + YW'(fy != '0);
    assign bil1 = (mode_reg == MODE_BILINEAR);
    assign dq   = dither_q(sy1_reg, sx1_reg);

    always_comb begin
        pdu = pu1_reg;
        pdv = pv1_reg;
        if (mode_reg == MODE_DITHER) begin
            pdu = pu1_reg + (PW'(dq[3:2]) << (UV_FRAC_BITS - 2));
            pdv = pv1_reg + (PW'(dq[1:0]) << (UV_FRAC_BITS - 2));
        end
        ru = (pdu + (PW'(1) << (UV_FRAC_BITS - 1))) >> UV_FRAC_BITS;
        rv = (pdv + (PW'(1) << (UV_FRAC_BITS - 1))) >> UV_FRAC_BITS;
        xr = (ru > PW'(wm1)) ? wm1 : XW'(ru);
        yr = (rv > PW'(hm1)) ? hm1 : YW'(rv);
        if (bil1) begin
            xa = x0; xb = x1; ya = y0; yb = y1;
        end else begin
            xa = xr; xb = xr; ya = yr; yb = yr;
        end
    end

    logic          wr_en;
    assign wr_en = en && v1_reg && (op1_reg == OP_WRITE);

    texel_t rd_reg [4];

    // four parity banks, one write and one read each
    for (genvar b = 0; b < 4; b++) begin : g_bank
        texel_t         mem [BDEP];
        logic [BAW-1:0] raddr;
        logic [XW-1:0]  bx;
        logic [YW-1:0]  by;
        assign bx    = (xa[0] == b[0]) ? xa : xb;
        assign by    = (ya[0] == b[1]) ? ya : yb;
        assign raddr = {by[YW-1:1], bx[XW-1:1]};
        always_ff @(posedge aclk) begin
            if (wr_en && tx1_reg[0] == b[0] && ty1_reg[0] == b[1]) begin
                mem[{ty1_reg[YW-1:1], tx1_reg[XW-1:1]}] <= tex1_reg;
            end
            if (en) begin
                rd_reg[b] <= mem[raddr];
            end
        end
    end

    logic v2_reg, bil2_reg, xa2_reg, xb2_reg, ya2_reg, yb2_reg;
    logic [UV_FRAC_BITS-1:0] fx2_reg, fy2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg && (op1_reg == OP_SAMPLE);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bil2_reg <= bil1;
            xa2_reg  <= xa[0];
            xb2_reg  <= xb[0];
            ya2_reg  <= ya[0];
            yb2_reg  <= yb[0];
            fx2_reg  <= fx;
            fy2_reg  <= fy;
        end
    end

    // stage 3: route bank data to neighbours and form the weights
    logic [UVW-1:0] ifx, ify;
    assign ifx = UV_ONE - UVW'(fx2_reg);
    assign ify = UV_ONE - UVW'(fy2_reg);

    logic          v3_reg, bil3_reg;
    texel_t        c3_reg [4];
    logic [WW-1:0] w3_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bil3_reg  <= bil2_reg;
            c3_reg[0] <= rd_reg[{ya2_reg, xa2_reg}];
            c3_reg[1] <= rd_reg[{ya2_reg, xb2_reg}];
            c3_reg[2] <= rd_reg[{yb2_reg, xa2_reg}];
            c3_reg[3] <= rd_reg[{yb2_reg, xb2_reg}];
            w3_reg[0] <= WW'(ifx * ify);
            w3_reg[1] <= WW'(UVW'(fx2_reg) * ify);
            w3_reg[2] <= WW'(ifx * UVW'(fy2_reg));
            w3_reg[3] <= WW'(UVW'(fx2_reg) * UVW'(fy2_reg));
        end
    end

    // stage 4: channel by weight products
    logic           v4_reg, bil4_reg;
    texel_t         near4_reg;
    logic [PRW-1:0] prod4_reg [4][4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bil4_reg  <= bil3_reg;
            near4_reg <= c3_reg[0];
            for (int ch = 0; ch < 4; ch++) begin
                for (int k = 0; k < 4; k++) begin
                    prod4_reg[ch][k] <= PRW'(c3_reg[k][8*ch +: 8] * w3_reg[k]);
                end
            end
        end
    end

    // stage 5: sum with rounding into the result register
    logic [ACW-1:0] acc [4];
    logic [7:0]     blend [4];
    texel_t         res_next, res_reg;

    always_comb begin
        for (int ch = 0; ch < 4; ch++) begin
            acc[ch] = (ACW'(1) << (2 * UV_FRAC_BITS - 1))
                    + ACW'(prod4_reg[ch][0]) + ACW'(prod4_reg[ch][1])
                    + ACW'(prod4_reg[ch][2]) + ACW'(prod4_reg[ch][3]);
            blend[ch] = ((acc[ch] >> (2 * UV_FRAC_BITS)) > ACW'(255)) ?
                        8'hFF : 8'(acc[ch] >> (2 * UV_FRAC_BITS));
        end
        if (bil4_reg) begin
            res_next = {blend[3], blend[2], blend[1], blend[0]};
        end else begin
            res_next = near4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = res_reg[7:0];
    assign m_out_green = res_reg[15:8];
    assign m_out_blue  = res_reg[23:16];
    assign m_out_alpha = res_reg[31:24];

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for texture_sampler_filtered_unit: texel writes, sampling in
// every filter mode and a range of size settings, checked against a behavioural colour predictor
// depends on tsf_pkg and the sampler rtl
module testbench;
    import tsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        op;
        logic [5:0]  tx;
        logic [5:0]  ty;
        logic [16:0] u;
        logic [16:0] v;
        logic        sxo;
        logic        syo;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
    } sample_req_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int FILL_SIZE      = 8;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_TEX_WIDTH;
    logic [6:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = OP_WRITE;
    logic [5:0]  s_texel_x = '0;
    logic [5:0]  s_texel_y = '0;
    logic [16:0] s_coord_u = '0;
    logic [16:0] s_coord_v = '0;
    logic        s_screen_x_odd = 1'b0;
    logic        s_screen_y_odd = 1'b0;
    logic [7:0]  s_texel_red = '0;
    logic [7:0]  s_texel_green = '0;
    logic [7:0]  s_texel_blue = '0;
    logic [7:0]  s_texel_alpha = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_red;
    logic [7:0]  m_out_green;
    logic [7:0]  m_out_blue;
    logic [7:0]  m_out_alpha;

    // predictor state
    texel_t      texel_mem [MAX_WIDTH*MAX_HEIGHT];
    int unsigned cur_width  = 64;
    int unsigned cur_height = 64;
    logic [1:0]  cur_mode   = MODE_NEAREST;
    texel_t      colour_q [$];

    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;

    texture_sampler_filtered_unit uut (.*);

    always #5 aclk = ~aclk;

    // scale a coordinate, saturated to one, by size minus one
    function automatic longint unsigned scale_uv(logic [16:0] c, int unsigned size);
        longint unsigned cv;
        cv = 64'(c);
        if (cv > 65536) cv = 65536;
        return cv * (size - 1);
    endfunction

    function automatic longint unsigned round_edge(longint unsigned p, int unsigned size);
        longint unsigned i;
        i = (p + 32768) >> 16;
        return (i > size - 1) ? size - 1 : i;
    endfunction

    // expected colour of one sample request
    function automatic texel_t predict_colour(sample_req_t q);
        longint unsigned pu, pv, x0, y0, x1, y1, fx, fy, acc;
        longint unsigned w [4];
        texel_t c [4];
        logic [3:0] dq;
        texel_t res;
        pu = scale_uv(q.u, cur_width);
        pv = scale_uv(q.v, cur_height);
        res = '0;
        if (cur_mode == MODE_BILINEAR) begin
            x0 = pu >> 16; y0 = pv >> 16;
            fx = pu & 16'hFFFF; fy = pv & 16'hFFFF;
            x1 = x0 + (fx != 0); y1 = y0 + (fy != 0);
            w[0] = (65536 - fx) * (65536 - fy);
            w[1] = fx * (65536 - fy);
            w[2] = (65536 - fx) * fy;
            w[3] = fx * fy;
            c[0] = texel_mem[y0*MAX_WIDTH + x0];
            c[1] = texel_mem[y0*MAX_WIDTH + x1];
            c[2] = texel_mem[y1*MAX_WIDTH + x0];
            c[3] = texel_mem[y1*MAX_WIDTH + x1];
            for (int ch = 0; ch < 4; ch++) begin
                acc = 64'd1 << 31;
                for (int k = 0; k < 4; k++)
                    acc += longint'(c[k][8*ch +: 8]) * w[k];
                acc >>= 32;
                res[8*ch +: 8] = (acc > 255) ? 8'd255 : acc[7:0];
            end
        end else begin
            if (cur_mode == MODE_DITHER) begin
                dq = dither_offsets(q.syo, q.sxo);
                pu += longint'(dq[3:2]) * 16384;
                pv += longint'(dq[1:0]) * 16384;
            end
            res = texel_mem[round_edge(pv, cur_height)*MAX_WIDTH + round_edge(pu, cur_width)];
        end
        return res;
    endfunction

    // ordered dither offsets in quarters {u, v}
    function automatic logic [3:0] dither_offsets(logic sy, logic sx);
        case ({sy, sx})
            2'b00:   return {2'd1, 2'd0};
            2'b01:   return {2'd2, 2'd3};
            2'b10:   return {2'd3, 2'd2};
            default: return {2'd0, 2'd1};
        endcase
    endfunction

    // send one request, with an optional gap first; called at a falling edge
    task automatic send_request(sample_req_t q);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= q.op; s_texel_x <= q.tx; s_texel_y <= q.ty;
        s_coord_u <= q.u; s_coord_v <= q.v;
        s_screen_x_odd <= q.sxo; s_screen_y_odd <= q.syo;
        s_texel_red <= q.r; s_texel_green <= q.g; s_texel_blue <= q.b; s_texel_alpha <= q.a;
        do @(posedge aclk); while (!s_ready);
        if (q.op == OP_WRITE)
            texel_mem[q.ty*MAX_WIDTH + q.tx] = {q.a, q.b, q.g, q.r};
        else
            colour_q.push_back(predict_colour(q));
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (colour_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // register write while idle, predictor copy saturates like the block
    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        wait_drained();
        cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TEX_WIDTH:   cur_width  = (val == 0) ? 1 : (val > MAX_WIDTH) ? MAX_WIDTH : val;
            REG_TEX_HEIGHT:  cur_height = (val == 0) ? 1 : (val > MAX_HEIGHT) ? MAX_HEIGHT : val;
            REG_FILTER_MODE: cur_mode   = val[1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [6:0] w, logic [6:0] h, logic [1:0] m);
        write_reg(REG_TEX_WIDTH, w);
        write_reg(REG_TEX_HEIGHT, h);
        write_reg(REG_FILTER_MODE, {5'd0, m});
    endtask

    function automatic sample_req_t rand_write(logic [5:0] x, logic [5:0] y);
        sample_req_t q;
        q.op = OP_WRITE; q.tx = x; q.ty = y;
        q.u = 17'($urandom()); q.v = 17'($urandom());
        q.sxo = 1'($urandom()); q.syo = 1'($urandom());
        q.r = 8'($urandom()); q.g = 8'($urandom());
        q.b = 8'($urandom()); q.a = 8'($urandom());
        return q;
    endfunction

    function automatic sample_req_t make_sample(logic [16:0] u, logic [16:0] v,
                                                 logic sx, logic sy);
        sample_req_t q;
        q = rand_write(6'($urandom()), 6'($urandom()));
        q.op = OP_SAMPLE; q.u = u; q.v = v; q.sxo = sx; q.syo = sy;
        return q;
    endfunction

    // random coordinate, mostly inside [0, 1], sometimes anywhere in the field
    function automatic logic [16:0] rand_uv();
        case ($urandom_range(0, 9))
            0:       return 17'($urandom_range(0, 131071));
            1:       return 17'd65536;
            2:       return 17'd0;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // every texel that a sample can reach gets a defined value first: a square
    // in the corner, the whole first row and the whole first column
    task automatic test_fill_store();
        for (int y = 0; y < FILL_SIZE; y++)
            for (int x = 0; x < FILL_SIZE; x++)
                send_request(rand_write(6'(x), 6'(y)));
        for (int x = FILL_SIZE; x < MAX_WIDTH; x++)
            send_request(rand_write(6'(x), 6'd0));
        for (int y = FILL_SIZE; y < MAX_HEIGHT; y++)
            send_request(rand_write(6'd0, 6'(y)));
    endtask

    task automatic test_directed();
        sample_req_t q;
        // full width along the first row
        set_config(7'd64, 7'd1, MODE_NEAREST);
        send_request(make_sample(17'd0, 17'd0, 1'b0, 1'b0));
        send_request(make_sample(17'd65536, 17'd65536, 1'b0, 1'b0));
        send_request(make_sample(17'h1FFFF, 17'h10001, 1'b1, 1'b1));
        send_request(make_sample(17'd32768, 17'd33288, 1'b0, 1'b1));
        // write followed straight away by a read of the same texel
        q = rand_write(6'd63, 6'd0);
        send_request(q);
        send_request(make_sample(17'd65536, 17'd0, 1'b0, 1'b0));
        // full height along the first column
        set_config(7'd1, 7'd64, MODE_NEAREST);
        send_request(make_sample(17'd0, 17'd65536, 1'b0, 1'b0));
        send_request(make_sample(17'd0, 17'h1FFFF, 1'b0, 1'b0));
        send_request(make_sample(17'd0, 17'd33288, 1'b0, 1'b0));
        set_config(7'd8, 7'd8, MODE_DITHER);
        for (int p = 0; p < 4; p++) begin
            send_request(make_sample(17'd65536, 17'd65536, p[0], p[1]));
            send_request(make_sample(17'd0, 17'd0, p[0], p[1]));
        end
        set_config(7'd8, 7'd8, MODE_BILINEAR);
        send_request(make_sample(17'd32768, 17'd32768, 1'b0, 1'b0));
        send_request(make_sample(17'd1, 17'd65535, 1'b0, 1'b0));
        send_request(make_sample(17'd65536, 17'd131071, 1'b0, 1'b0));
        set_config(7'd64, 7'd1, MODE_BILINEAR);
        send_request(make_sample(17'd32768, 17'd0, 1'b0, 1'b0));
        send_request(make_sample(17'd65535, 17'd40000, 1'b0, 1'b0));
        // size zero acts as one, oversize saturates, mode three samples as nearest
        set_config(7'd0, 7'd127, 2'd3);
        send_request(make_sample(17'd65536, 17'd65536, 1'b0, 1'b0));
        send_request(make_sample(17'd40000, 17'd20000, 1'b1, 1'b0));
    endtask

    task automatic test_random(logic [6:0] w, logic [6:0] h, logic [1:0] m, int n);
        set_config(w, h, m);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 3)
                send_request(rand_write(6'($urandom()), 6'($urandom())));
            else
                send_request(make_sample(rand_uv(), rand_uv(),
                                         1'($urandom()), 1'($urandom())));
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        texel_t exp_c;
        if (aresetn && m_valid && m_ready) begin
            if (colour_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", {m_out_alpha, m_out_blue,
                             m_out_green, m_out_red});
            end else begin
                exp_c = colour_q.pop_front();
                if (m_out_red !== exp_c[7:0] || m_out_green !== exp_c[15:8] ||
                    m_out_blue !== exp_c[23:16] || m_out_alpha !== exp_c[31:24]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("colour mismatch: expected r%h g%h b%h a%h got r%h g%h b%h a%h",
                                 exp_c[7:0], exp_c[15:8], exp_c[23:16], exp_c[31:24],
                                 m_out_red, m_out_green, m_out_blue, m_out_alpha);
                end
            end
        end
    end

    // result side back-pressure in bursts
    always @(negedge aclk) begin
        int hold;
        if (calm || !aresetn) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 15);
            m_ready <= 1'b0;
            repeat (hold - 1) @(negedge aclk);
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_fill_store();
        test_directed();
        test_random(7'd8, 7'd8, MODE_NEAREST, 40);
        test_random(7'd1, 7'd1, MODE_DITHER, 20);
        test_random(7'd7, 7'd5, MODE_BILINEAR, 40);
        test_random(7'd64, 7'd1, MODE_DITHER, 30);
        test_random(7'd1, 7'd64, MODE_BILINEAR, 30);
        test_random(7'd127, 7'd0, 2'd3, 20);
        calm = 1'b1;
        test_random(7'd8, 7'd8, MODE_BILINEAR, 40);
        wait_drained();
        if (colour_q.size() != 0) mismatches++;
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
